FILE: rtl/swrl_pkg.sv
package swrl_pkg;

   // Capacity of the window (number of stored samples).
   localparam int WIN_CAP = 256;
   // Bits needed to hold a window length from 0 up to WIN_CAP.
   localparam int LEN_W   = $clog2(WIN_CAP + 1);
   // Width of the length fields on the result channel.
   localparam int OUT_W   = 9;
   localparam int DATA_W  = 32;

   // Control fanned out from the sequencer to every cell in the row.
   typedef struct packed {
      logic                     load;    // shift in a new sample
      logic                     update;  // recompute the in-window bits
      logic signed [DATA_W-1:0] sample;
      logic        [DATA_W-1:0] limit;
   } swrl_ctl_type;

endpackage

FILE: rtl/swrl_cell.sv
// One window position. Holds the running max/min of the new sample and all
// newer positions, plus a bit saying whether this position is in the window.
module swrl_cell
   import swrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  swrl_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] nb_pmax,
   input  logic signed [DATA_W-1:0] nb_pmin,
   input  logic                     nb_win,
   output logic signed [DATA_W-1:0] pmax,
   output logic signed [DATA_W-1:0] pmin,
   output logic                     win
);

   logic signed [DATA_W-1:0] pmax_ff, pmax_in;
   logic signed [DATA_W-1:0] pmin_ff, pmin_in;
   logic                     win_ff, win_in;
   logic        [DATA_W:0]   spread;

   always_comb begin
      pmax_in = (ctl.sample > nb_pmax) ? ctl.sample : nb_pmax;
      pmin_in = (ctl.sample < nb_pmin) ? ctl.sample : nb_pmin;
      // exact 33-bit range, never negative
      spread  = {pmax_ff[DATA_W-1], pmax_ff} - {pmin_ff[DATA_W-1], pmin_ff};
      win_in  = nb_win && (spread <= {1'b0, ctl.limit});
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pmax_ff <= pmax_in;
         pmin_ff <= pmin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 1'b0;
      end else if (ctl.update) begin
         win_ff <= win_in;
      end
   end

   assign pmax = pmax_ff;
   assign pmin = pmin_ff;
   assign win  = win_ff;

endmodule

FILE: rtl/swrl_len_enc.sv
// Thermometer (in-window bits) to window length.
module swrl_len_enc
   import swrl_pkg::*;
(
   input  logic [WIN_CAP-1:0] win,
   output logic [LEN_W-1:0]   len
);

   logic [WIN_CAP-1:0] edge_bits;

   always_comb begin
      edge_bits = win & ~{1'b0, win[WIN_CAP-1:1]};
      len = '0;
      for (int m = 0; m < WIN_CAP; m++) begin
         len = len | ({LEN_W{edge_bits[m]}} & LEN_W'(m + 1));
      end
   end

endmodule

FILE: rtl/sliding_window_range_limit_length.sv
// Channel   Dir  Handshake           Payload
// req       in   req_valid/req_stall req_sample, req_start_req
// rsp       out  rsp_valid/rsp_stall rsp_window_length, rsp_best_length, rsp_capacity_hit
// csr       in   csr_wr_en           csr_wr_data (range_limit)
//
// Per word: the accept edge shifts the row of cells, the CMP state updates
// every in-window bit, and the ENC state encodes the length into the result
// register on the same edge that may also accept the next word.
// Reset is synchronous; it empties the window and clears best length and limit.
// A stalled result register holds the sequencer, which then stalls req.
module sliding_window_range_limit_length
   import swrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_start_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_W-1:0]         rsp_window_length,
   output logic [OUT_W-1:0]         rsp_best_length,
   output logic                     rsp_capacity_hit,
   input  logic                     csr_wr_en,
   input  logic [DATA_W-1:0]        csr_wr_data
);

   typedef enum logic [1:0] {IDLE, CMP, ENC} state_type;

   state_type          state_ff;
   logic               start_ff;
   logic [DATA_W-1:0]  limit_ff;
   logic [LEN_W-1:0]   best_ff, best_in;
   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   rsp_len_ff, rsp_best_ff;
   logic               rsp_hit_ff;

   logic               accept;
   logic               slot_free;
   logic [LEN_W-1:0]   len;
   swrl_ctl_type       ctl;

   // Cell k sits at age k after the shift; cell WIN_CAP is a spare position
   // that only tells whether the window wanted to grow past capacity.
   logic signed [DATA_W-1:0] pmax_q [0:WIN_CAP];
   logic signed [DATA_W-1:0] pmin_q [0:WIN_CAP];
   logic        [WIN_CAP:0]  win_q;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == IDLE) || (state_ff == ENC && slot_free));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctl.load   = accept;
      ctl.update = (state_ff == CMP);
      ctl.sample = req_sample;
      ctl.limit  = limit_ff;
   end

   // Cell 0 always holds the new sample and is always in the window.
   swrl_cell u_cell0 (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .nb_pmax (req_sample),
      .nb_pmin (req_sample),
      .nb_win  (1'b1),
      .pmax    (pmax_q[0]),
      .pmin    (pmin_q[0]),
      .win     (win_q[0])
   );

   for (genvar k = 1; k <= WIN_CAP; k++) begin : g_cell
      swrl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .nb_pmax (pmax_q[k-1]),
         .nb_pmin (pmin_q[k-1]),
         .nb_win  (win_q[k-1] && !start_ff), // start empties the old window
         .pmax    (pmax_q[k]),
         .pmin    (pmin_q[k]),
         .win     (win_q[k])
      );
   end

   swrl_len_enc u_enc (
      .win (win_q[WIN_CAP-1:0]),
      .len (len)
   );

   always_comb begin
      if (start_ff || len > best_ff) begin
         best_in = len;
      end else begin
         best_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         start_ff     <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  start_ff <= req_start_req;
                  state_ff <= CMP;
               end
            end
            CMP: begin
               state_ff <= ENC;
            end
            ENC: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_len_ff   <= OUT_W'(len);
                  rsp_best_ff  <= OUT_W'(best_in);
                  rsp_hit_ff   <= win_q[WIN_CAP];
                  best_ff      <= best_in;
                  if (accept) begin
                     start_ff <= req_start_req;
                     state_ff <= CMP;
                  end else begin
                     state_ff <= IDLE;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_length = rsp_len_ff;
   assign rsp_best_length   = rsp_best_ff;
   assign rsp_capacity_hit  = rsp_hit_ff;

`ifndef NO_ASSERTIONS
   a_newest_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENC |-> win_q[0])
      else $error("newest cell not in window");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_len_ff != '0)
      else $error("zero window length");

   a_best_covers_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_best_ff >= rsp_len_ff)
      else $error("best length below window length");

   a_hit_at_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_len_ff == OUT_W'(WIN_CAP))
      else $error("capacity hit without full window");

   a_accept_to_cmp: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == CMP)
      else $error("accepted word not processed");
`endif

endmodule
